FILE: src/svwm_pkg.sv
`default_nettype none

package svwm_pkg;

    // Field widths fixed by the interface
    localparam int ADC_W      = 12;
    localparam int VOLT_W     = 9;
    localparam int HYST_W     = 6;
    localparam int CNT_W      = 8;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    // Conversion to tenths of a volt: (((s * 33 * 110) >> SAMPLE_BITS) + 5) / 10
    localparam int                SCALED_W    = 12;
    localparam logic [11:0]       SCALE_MUL   = 12'd3630;
    localparam logic [3:0]        ROUND_OFS   = 4'd5;
    // Divide by ten as a reciprocal multiply, exact for inputs below 2^14
    localparam logic [15:0]       DIV10_MUL   = 16'd52429;
    localparam int                DIV10_SHIFT = 19;
    localparam int                QUOT_W      = SCALED_W + 16;

    localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};

    // Reset values of the configuration registers
    localparam logic [VOLT_W-1:0] LOW_TH_RST  = 9'd90;
    localparam logic [VOLT_W-1:0] HIGH_TH_RST = 9'd160;
    localparam logic [HYST_W-1:0] HYST_RST    = 6'd5;
    localparam logic [CNT_W-1:0]  DEBOUNCE_RST = 8'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_THRESHOLD  = 2'd0,
        REG_HIGH_THRESHOLD = 2'd1,
        REG_HYSTERESIS     = 2'd2,
        REG_DEBOUNCE_LIMIT = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_UNINIT = 2'd0,
        ST_NORMAL = 2'd1,
        ST_OVER   = 2'd2,
        ST_LOW    = 2'd3
    } supply_state_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_ENABLE  = 2'd1,
        ACT_DISABLE = 2'd2
    } comm_action_t;

    typedef struct packed {
        logic [VOLT_W-1:0] low_threshold;
        logic [VOLT_W-1:0] high_threshold;
        logic [HYST_W-1:0] hysteresis;
        logic [CNT_W-1:0]  debounce_limit;
    } cfg_t;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage;
        supply_state_t     supply_state;
        logic              state_changed;
        comm_action_t      comm_action;
        logic              under_voltage_fault;
        logic              over_voltage_fault;
        logic              start_confirm_delay;
        logic              stop_confirm_delay;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
        return (cnt == CNT_MAX) ? CNT_MAX : cnt + 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: src/svwm_cfg.sv
`default_nettype none

module svwm_cfg
    import svwm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_threshold  <= LOW_TH_RST;
            cfg_reg.high_threshold <= HIGH_TH_RST;
            cfg_reg.hysteresis     <= HYST_RST;
            cfg_reg.debounce_limit <= DEBOUNCE_RST;
        end
        else if (cfg_write)
        begin
            // keep only the register's own width
            case (cfg_index_t'(cfg_index))
                REG_LOW_THRESHOLD:  cfg_reg.low_threshold  <= cfg_data[VOLT_W-1:0];
                REG_HIGH_THRESHOLD: cfg_reg.high_threshold <= cfg_data[VOLT_W-1:0];
                REG_HYSTERESIS:     cfg_reg.hysteresis     <= cfg_data[HYST_W-1:0];
                REG_DEBOUNCE_LIMIT: cfg_reg.debounce_limit <= cfg_data[CNT_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: src/svwm_scale.sv
`default_nettype none

module svwm_scale
    import svwm_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  wire logic [ADC_W-1:0]    sample,
    output logic      [SCALED_W-1:0] scaled
);

    localparam int USE_W  = (SAMPLE_BITS < ADC_W) ? SAMPLE_BITS : ADC_W;
    localparam int PROD_W = USE_W + 12;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] shifted;

    // s * 3630 / 2^SAMPLE_BITS, then add the rounding offset ahead of the divide by ten
    always_comb
    begin
        prod    = PROD_W'(sample[USE_W-1:0]) * PROD_W'(SCALE_MUL);
        shifted = prod >> SAMPLE_BITS;
        scaled  = shifted[SCALED_W-1:0] + SCALED_W'(ROUND_OFS);
    end

endmodule

`default_nettype wire

FILE: src/svwm_supervisor.sv
`default_nettype none

module svwm_supervisor
    import svwm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                update,
    input  wire logic [SCALED_W-1:0] scaled,
    input  cfg_t                     cfg,
    output result_t                  result
);

    supply_state_t    state_reg, state_next;
    logic [CNT_W-1:0] low_count_reg, low_count_next;
    logic [CNT_W-1:0] over_count_reg, over_count_next;
    logic [CNT_W-1:0] normal_count_reg, normal_count_next;
    logic             low_fault_reg, low_fault_next;
    logic             high_fault_reg, high_fault_next;

    logic [QUOT_W-1:0] quot;
    logic [VOLT_W-1:0] voltage;
    logic              below_low;
    logic              above_high;
    logic [VOLT_W-1:0] over_exit_lvl;
    logic [VOLT_W:0]   under_exit_lvl;
    logic              recover;
    logic              changed;
    comm_action_t      action;
    logic              start_delay;
    logic              stop_delay;

    always_comb
    begin
        quot    = QUOT_W'(scaled) * QUOT_W'(DIV10_MUL);
        voltage = VOLT_W'(quot >> DIV10_SHIFT);

        below_low      = voltage < cfg.low_threshold;
        above_high     = voltage > cfg.high_threshold;
        // recovery level in over-voltage saturates at zero
        over_exit_lvl  = (cfg.high_threshold > VOLT_W'(cfg.hysteresis))
                       ? cfg.high_threshold - VOLT_W'(cfg.hysteresis) : '0;
        under_exit_lvl = {1'b0, cfg.low_threshold} + (VOLT_W + 1)'(cfg.hysteresis);
        recover        = (state_reg == ST_OVER) ? (voltage < over_exit_lvl)
                       : ({1'b0, voltage} > under_exit_lvl);

        state_next        = state_reg;
        low_count_next    = low_count_reg;
        over_count_next   = over_count_reg;
        normal_count_next = normal_count_reg;
        low_fault_next    = low_fault_reg;
        high_fault_next   = high_fault_reg;

        case (state_reg)
            ST_UNINIT, ST_NORMAL:
            begin
                if (below_low)
                begin
                    if (low_count_reg > cfg.debounce_limit)
                    begin
                        state_next     = ST_LOW;
                        low_count_next = '0;
                    end
                    else
                    begin
                        low_count_next    = sat_inc(low_count_reg);
                        over_count_next   = '0;
                        normal_count_next = '0;
                    end
                end
                else if (above_high)
                begin
                    if (over_count_reg > cfg.debounce_limit)
                    begin
                        state_next      = ST_OVER;
                        over_count_next = '0;
                    end
                    else
                    begin
                        over_count_next   = sat_inc(over_count_reg);
                        low_count_next    = '0;
                        normal_count_next = '0;
                    end
                end
                else if (state_reg == ST_UNINIT)
                begin
                    if (normal_count_reg > cfg.debounce_limit)
                    begin
                        state_next        = ST_NORMAL;
                        normal_count_next = '0;
                    end
                    else
                    begin
                        normal_count_next = sat_inc(normal_count_reg);
                        low_count_next    = '0;
                        over_count_next   = '0;
                    end
                end
                else
                begin
                    low_count_next    = '0;
                    over_count_next   = '0;
                    normal_count_next = '0;
                end
            end
            ST_OVER, ST_LOW:
            begin
                if (recover)
                begin
                    if (normal_count_reg > cfg.debounce_limit)
                    begin
                        state_next        = ST_NORMAL;
                        normal_count_next = '0;
                    end
                    else
                    begin
                        normal_count_next = sat_inc(normal_count_reg);
                        low_count_next    = '0;
                        over_count_next   = '0;
                    end
                end
                else
                begin
                    low_count_next    = '0;
                    over_count_next   = '0;
                    normal_count_next = '0;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase

        changed     = state_next != state_reg;
        action      = ACT_NONE;
        start_delay = 1'b0;
        stop_delay  = 1'b0;
        if (changed)
        begin
            case (state_next)
                ST_NORMAL:
                begin
                    action          = ACT_ENABLE;
                    start_delay     = 1'b1;
                    low_fault_next  = 1'b0;
                    high_fault_next = 1'b0;
                end
                ST_LOW:
                begin
                    action          = ACT_DISABLE;
                    stop_delay      = 1'b1;
                    low_fault_next  = 1'b1;
                    high_fault_next = 1'b0;
                end
                default:
                begin
                    action          = ACT_DISABLE;
                    stop_delay      = 1'b1;
                    low_fault_next  = 1'b0;
                    high_fault_next = 1'b1;
                end
            endcase
        end

        result.voltage             = voltage;
        result.supply_state        = state_next;
        result.state_changed       = changed;
        result.comm_action         = action;
        result.under_voltage_fault = low_fault_next;
        result.over_voltage_fault  = high_fault_next;
        result.start_confirm_delay = start_delay;
        result.stop_confirm_delay  = stop_delay;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_UNINIT;
            low_count_reg    <= '0;
            over_count_reg   <= '0;
            normal_count_reg <= '0;
            low_fault_reg    <= 1'b0;
            high_fault_reg   <= 1'b0;
        end
        else if (update)
        begin
            state_reg        <= state_next;
            low_count_reg    <= low_count_next;
            over_count_reg   <= over_count_next;
            normal_count_reg <= normal_count_next;
            low_fault_reg    <= low_fault_next;
            high_fault_reg   <= high_fault_next;
        end
    end

    // once out of uninit the supervisor never goes back
    a_no_return_uninit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_UNINIT |=> state_reg != ST_UNINIT)
        else $error("supervisor returned to uninit");

    a_faults_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(low_fault_reg && high_fault_reg))
        else $error("both fault flags set");

    // faults follow the state: normal clears both, low sets only under, over only over
    a_fault_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        update && changed |=> (state_reg == ST_LOW) == low_fault_reg
                              && (state_reg == ST_OVER) == high_fault_reg)
        else $error("fault flags disagree with new state");

endmodule

`default_nettype wire

FILE: src/supply_voltage_window_monitor.sv
`default_nettype none

// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+-------------------------------------------
// input     | in        | in_valid / in_stall | adc_sample
// result    | out       | out_valid/out_stall | voltage, supply_state, state_changed,
//           |           |                     | comm_action, under/over_voltage_fault,
//           |           |                     | start/stop_confirm_delay
// config    | in        | cfg_write           | cfg_index, cfg_data
//
// One request is taken per cycle while in_stall is low; each yields one result.
// Three register stages: sample, scaled product, result. The supervisor state advances
// as a request moves from the scaled stage into the result register.
// Reset (rst_n low, asynchronous) empties the pipe, puts the supervisor in uninit with
// counts and faults clear, and loads the default thresholds.
// A stalled result holds; upstream stages keep filling until every stage is occupied,
// then in_stall rises.

module supply_voltage_window_monitor
    import svwm_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [ADC_W-1:0]      adc_sample,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [VOLT_W-1:0]     voltage,
    output logic      [1:0]            supply_state,
    output logic                       state_changed,
    output logic      [1:0]            comm_action,
    output logic                       under_voltage_fault,
    output logic                       over_voltage_fault,
    output logic                       start_confirm_delay,
    output logic                       stop_confirm_delay,

    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                cfg;
    logic                smp_valid_reg;
    logic [ADC_W-1:0]    smp_reg;
    logic                scl_valid_reg;
    logic [SCALED_W-1:0] scl_reg;
    logic [SCALED_W-1:0] scaled_next;
    logic                out_valid_reg;
    result_t             result_reg;
    result_t             result_next;

    logic out_load;
    logic scl_load;
    logic smp_load;

    // each stage loads when it is empty or its contents move on
    assign out_load = !out_valid_reg || !out_stall;
    assign scl_load = !scl_valid_reg || out_load;
    assign smp_load = !smp_valid_reg || scl_load;
    assign in_stall = !smp_load;

    svwm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    svwm_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .sample (smp_reg),
        .scaled (scaled_next)
    );

    // advance the supervisor only when a request actually enters the result register
    svwm_supervisor u_supervisor (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (scl_valid_reg && out_load),
        .scaled (scl_reg),
        .cfg    (cfg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg <= 1'b0;
            scl_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (smp_load)
            begin
                smp_valid_reg <= in_valid;
            end
            if (scl_load)
            begin
                scl_valid_reg <= smp_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= scl_valid_reg;
            end
        end
    end

    // payload stages, no reset needed
    always_ff @(posedge clk)
    begin
        if (smp_load)
        begin
            smp_reg <= adc_sample;
        end
        if (scl_load)
        begin
            scl_reg <= scaled_next;
        end
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign voltage             = result_reg.voltage;
    assign supply_state        = result_reg.supply_state;
    assign state_changed       = result_reg.state_changed;
    assign comm_action         = result_reg.comm_action;
    assign under_voltage_fault = result_reg.under_voltage_fault;
    assign over_voltage_fault  = result_reg.over_voltage_fault;
    assign start_confirm_delay = result_reg.start_confirm_delay;
    assign stop_confirm_delay  = result_reg.stop_confirm_delay;

    // a scaled request that cannot move on must not be overwritten
    a_scl_hold: assert property (@(posedge clk) disable iff (!rst_n)
        scl_valid_reg && !out_load |=> scl_valid_reg && $stable(scl_reg))
        else $error("scaled stage lost a request");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(result_reg))
        else $error("stalled result changed");

    // input stalls only with every stage occupied and the result held off
    a_in_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> smp_valid_reg && scl_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in the pipe");

endmodule

`default_nettype wire
